FILE: design/cursor_overlay_alpha_blend_assert.svh
// Assertion macros for the cursor overlay blend checker.
// Plain text only; needs a clk and an active-low rst_n in the including scope.
`ifndef CURSOR_OVERLAY_ALPHA_BLEND_ASSERT_SVH
`define CURSOR_OVERLAY_ALPHA_BLEND_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define COAB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define COAB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/coab_pkg.sv
// Shared constants and types for the cursor overlay alpha blend.
// No dependencies; used by the top level and its checker.
package coab_pkg;

  localparam int MAX_CURSOR_SIDE = 256;
  localparam int MAX_FRAME_SIDE  = 8192;

  localparam int POS_W   = 13;
  localparam int HOT_W   = 8;
  localparam int DIM_W   = 14;
  localparam int LINE_W  = 16;
  localparam int ADDR_W  = 28;
  localparam int BYTE_W  = 8;
  localparam int ARGB_W  = 32;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int SIGNED_POS_W = 15;

  localparam logic [BYTE_W-1:0]  FULL_ALPHA  = 8'd255;
  localparam logic [15:0]        HALF_ROUND  = 16'(255 / 2);
  // x / 255 == (x * 32897) >> 23 for every 16-bit x
  localparam logic [31:0]        RECIP_255   = 32'd32897;
  localparam int                 RECIP_SHIFT = 23;
  localparam int                 ALPHA_LSB   = 24;

  localparam logic [DIM_W-1:0]  WIDTH_RST  = 14'd1920;
  localparam logic [DIM_W-1:0]  HEIGHT_RST = 14'd1080;
  localparam logic [LINE_W-1:0] LINE_RST   = 16'd7680;
  localparam logic [DIM_W-1:0]  FRAME_LIM  = DIM_W'(MAX_FRAME_SIDE);

  typedef enum logic [2:0] {
    REG_POINTER_X    = 3'd0,
    REG_POINTER_Y    = 3'd1,
    REG_HOT_X        = 3'd2,
    REG_HOT_Y        = 3'd3,
    REG_FRAME_WIDTH  = 3'd4,
    REG_FRAME_HEIGHT = 3'd5,
    REG_LINE_BYTES   = 3'd6
  } cfg_idx_t;

endpackage

FILE: design/cursor_overlay_alpha_blend.sv
// An accepted item passes through the stage 1, stage 2 and output registers in order and
// can be taken from the output register whenever out_stall is low.
// Throughput: one item per cycle while the output is not stalled; the three stages hold or
// advance together, so a stalled valid output holds the whole pipe and raises in_stall.
// Stage 1 multiplies frame by 255-alpha, stage 2 runs the reciprocal multiply and
// row*line_bytes, stage 3 adds and selects. Synchronous rst_n clears valids, loads reg resets.
module cursor_overlay_alpha_blend (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [coab_pkg::PADDR_W-1:0]      paddr,
  input  logic [coab_pkg::PDATA_W-1:0]      pwdata,
  output logic [coab_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [coab_pkg::BYTE_W-1:0]       in_cursor_col,
  input  logic [coab_pkg::BYTE_W-1:0]       in_cursor_row,
  input  logic [coab_pkg::ARGB_W-1:0]       in_cursor_argb,
  input  logic [coab_pkg::BYTE_W-1:0]       in_frame_byte0,
  input  logic [coab_pkg::BYTE_W-1:0]       in_frame_byte1,
  input  logic [coab_pkg::BYTE_W-1:0]       in_frame_byte2,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_write_enable,
  output logic [coab_pkg::ADDR_W-1:0]       out_byte_address,
  output logic [coab_pkg::BYTE_W-1:0]       out_new_byte0,
  output logic [coab_pkg::BYTE_W-1:0]       out_new_byte1,
  output logic [coab_pkg::BYTE_W-1:0]       out_new_byte2
);

  // configuration registers
  logic [coab_pkg::POS_W-1:0]  pointer_x_r, pointer_y_r;
  logic [coab_pkg::HOT_W-1:0]  hot_x_r, hot_y_r;
  logic [coab_pkg::DIM_W-1:0]  frame_width_r, frame_height_r;
  logic [coab_pkg::LINE_W-1:0] line_bytes_r;
  logic                        cfg_wr;
  coab_pkg::cfg_idx_t          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = coab_pkg::cfg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pointer_x_r    <= '0;
      pointer_y_r    <= '0;
      hot_x_r        <= '0;
      hot_y_r        <= '0;
      frame_width_r  <= coab_pkg::WIDTH_RST;
      frame_height_r <= coab_pkg::HEIGHT_RST;
      line_bytes_r   <= coab_pkg::LINE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        coab_pkg::REG_POINTER_X:    pointer_x_r    <= pwdata[coab_pkg::POS_W-1:0];
        coab_pkg::REG_POINTER_Y:    pointer_y_r    <= pwdata[coab_pkg::POS_W-1:0];
        coab_pkg::REG_HOT_X:        hot_x_r        <= pwdata[coab_pkg::HOT_W-1:0];
        coab_pkg::REG_HOT_Y:        hot_y_r        <= pwdata[coab_pkg::HOT_W-1:0];
        coab_pkg::REG_FRAME_WIDTH:  frame_width_r  <= pwdata[coab_pkg::DIM_W-1:0];
        coab_pkg::REG_FRAME_HEIGHT: frame_height_r <= pwdata[coab_pkg::DIM_W-1:0];
        coab_pkg::REG_LINE_BYTES:   line_bytes_r   <= pwdata[coab_pkg::LINE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      coab_pkg::REG_POINTER_X:    prdata = 32'(pointer_x_r);
      coab_pkg::REG_POINTER_Y:    prdata = 32'(pointer_y_r);
      coab_pkg::REG_HOT_X:        prdata = 32'(hot_x_r);
      coab_pkg::REG_HOT_Y:        prdata = 32'(hot_y_r);
      coab_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width_r);
      coab_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height_r);
      coab_pkg::REG_LINE_BYTES:   prdata = 32'(line_bytes_r);
      default:                    prdata = '0;
    endcase
  end

  // pipeline control: all stages move together
  logic v1_r, v2_r, v3_r;
  logic adv;

  assign adv      = !v3_r || !out_stall;
  assign in_stall = !adv;

  // ---------------- stage 1: position, clip, frame share product
  logic signed [coab_pkg::SIGNED_POS_W-1:0] ix_nxt, iy_nxt;
  logic [coab_pkg::DIM_W-1:0]  wlim, hlim;
  logic [coab_pkg::BYTE_W-1:0] alpha, inv_alpha;
  logic                        on_frame, we1_nxt;
  logic [15:0]                 p0_nxt, p1_nxt, p2_nxt;

  always_comb begin
    alpha     = in_cursor_argb[coab_pkg::ALPHA_LSB +: coab_pkg::BYTE_W];
    inv_alpha = coab_pkg::FULL_ALPHA - alpha;
    ix_nxt = $signed({2'b00, pointer_x_r}) - $signed({7'b0, hot_x_r})
           + $signed({7'b0, in_cursor_col});
    iy_nxt = $signed({2'b00, pointer_y_r}) - $signed({7'b0, hot_y_r})
           + $signed({7'b0, in_cursor_row});
    wlim = (frame_width_r  > coab_pkg::FRAME_LIM) ? coab_pkg::FRAME_LIM : frame_width_r;
    hlim = (frame_height_r > coab_pkg::FRAME_LIM) ? coab_pkg::FRAME_LIM : frame_height_r;
    on_frame = !ix_nxt[coab_pkg::SIGNED_POS_W-1] && !iy_nxt[coab_pkg::SIGNED_POS_W-1]
          && (ix_nxt[coab_pkg::DIM_W-1:0] < wlim) && (iy_nxt[coab_pkg::DIM_W-1:0] < hlim)
          && ({1'b0, in_cursor_col} < 9'(coab_pkg::MAX_CURSOR_SIDE))
          && ({1'b0, in_cursor_row} < 9'(coab_pkg::MAX_CURSOR_SIDE));
    we1_nxt = on_frame && (alpha != '0);
    p0_nxt  = 16'(in_frame_byte0) * 16'(inv_alpha);
    p1_nxt  = 16'(in_frame_byte1) * 16'(inv_alpha);
    p2_nxt  = 16'(in_frame_byte2) * 16'(inv_alpha);
  end

  logic                        we1_r;
  logic [coab_pkg::POS_W-1:0]  ix1_r, iy1_r;
  logic [15:0]                 p0_r, p1_r, p2_r;
  logic [coab_pkg::BYTE_W-1:0] c0_1_r, c1_1_r, c2_1_r, f0_1_r, f1_1_r, f2_1_r;

  // ---------------- stage 2: divide by 255 and row times line length
  logic [31:0] q0_nxt, q1_nxt, q2_nxt;
  logic [coab_pkg::ADDR_W-1:0] rowoff_nxt;
  logic [28:0] rowmul;

  always_comb begin
    q0_nxt     = 32'(p0_r + coab_pkg::HALF_ROUND) * coab_pkg::RECIP_255;
    q1_nxt     = 32'(p1_r + coab_pkg::HALF_ROUND) * coab_pkg::RECIP_255;
    q2_nxt     = 32'(p2_r + coab_pkg::HALF_ROUND) * coab_pkg::RECIP_255;
    rowmul     = 29'(iy1_r) * 29'(line_bytes_r);
    rowoff_nxt = rowmul[coab_pkg::ADDR_W-1:0];
  end

  logic                        we2_r;
  logic [coab_pkg::POS_W-1:0]  ix2_r;
  logic [coab_pkg::ADDR_W-1:0] rowoff2_r;
  logic [coab_pkg::BYTE_W-1:0] s0_r, s1_r, s2_r;
  logic [coab_pkg::BYTE_W-1:0] c0_2_r, c1_2_r, c2_2_r, f0_2_r, f1_2_r, f2_2_r;

  // ---------------- stage 3: final add and select
  logic [coab_pkg::ADDR_W-1:0] addr_nxt;
  logic [coab_pkg::BYTE_W-1:0] b0_nxt, b1_nxt, b2_nxt;

  always_comb begin
    if (we2_r) begin
      addr_nxt = rowoff2_r + {13'b0, ix2_r, 2'b00};
      b0_nxt   = c0_2_r + s0_r;
      b1_nxt   = c1_2_r + s1_r;
      b2_nxt   = c2_2_r + s2_r;
    end else begin
      addr_nxt = '0;
      b0_nxt   = f0_2_r;
      b1_nxt   = f1_2_r;
      b2_nxt   = f2_2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // payload: hold while stalled
  always_ff @(posedge clk) begin
    if (adv) begin
      we1_r  <= we1_nxt;
      ix1_r  <= ix_nxt[coab_pkg::POS_W-1:0];
      iy1_r  <= iy_nxt[coab_pkg::POS_W-1:0];
      p0_r   <= p0_nxt;
      p1_r   <= p1_nxt;
      p2_r   <= p2_nxt;
      c0_1_r <= in_cursor_argb[7:0];
      c1_1_r <= in_cursor_argb[15:8];
      c2_1_r <= in_cursor_argb[23:16];
      f0_1_r <= in_frame_byte0;
      f1_1_r <= in_frame_byte1;
      f2_1_r <= in_frame_byte2;

      we2_r     <= we1_r;
      ix2_r     <= ix1_r;
      rowoff2_r <= rowoff_nxt;
      s0_r      <= q0_nxt[coab_pkg::RECIP_SHIFT +: coab_pkg::BYTE_W];
      s1_r      <= q1_nxt[coab_pkg::RECIP_SHIFT +: coab_pkg::BYTE_W];
      s2_r      <= q2_nxt[coab_pkg::RECIP_SHIFT +: coab_pkg::BYTE_W];
      c0_2_r    <= c0_1_r;
      c1_2_r    <= c1_1_r;
      c2_2_r    <= c2_1_r;
      f0_2_r    <= f0_1_r;
      f1_2_r    <= f1_1_r;
      f2_2_r    <= f2_1_r;

      out_write_enable <= we2_r;
      out_byte_address <= addr_nxt;
      out_new_byte0    <= b0_nxt;
      out_new_byte1    <= b1_nxt;
      out_new_byte2    <= b2_nxt;
    end
  end

  assign out_valid = v3_r;

endmodule

FILE: design/coab_checker.sv
// Port-level checker for the cursor overlay blend, bound to the top level.
// Depends on coab_pkg and the assertion macros header.
`include "cursor_overlay_alpha_blend_assert.svh"

module coab_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_write_enable,
  input logic [coab_pkg::ADDR_W-1:0] out_byte_address,
  input logic [coab_pkg::BYTE_W-1:0] out_new_byte0,
  input logic [coab_pkg::BYTE_W-1:0] out_new_byte1,
  input logic [coab_pkg::BYTE_W-1:0] out_new_byte2
);

  // a held item keeps its payload
  `COAB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte_address) && $stable(out_new_byte0) && $stable(out_new_byte1) && $stable(out_new_byte2) && $stable(out_write_enable), "stalled output item changed")

  // no write means a zero address
  `COAB_ASSERT_NOW(a_nowrite_addr, out_valid && !out_write_enable, out_byte_address == '0, "address nonzero on item without write")

  // the pipe only holds input while the output side is blocked
  `COAB_ASSERT_NOW(a_stall_cause, !(out_valid && out_stall), !in_stall, "input stalled with free output")

endmodule

bind cursor_overlay_alpha_blend coab_checker u_coab_checker (.*);
